// ===== hdl/gha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gha_pkg;

  localparam int unsigned SlotCountDef = 512;

  localparam int unsigned OpW      = 2;
  localparam int unsigned SlotIdxW = 10;
  localparam int unsigned GenW     = 8;
  localparam int unsigned KindW    = 4;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned ResSlotW = 9;

  // Generations count modulo 255, so 255 itself never matches.
  localparam logic [GenW-1:0] GenMax = GenW'(254);

  typedef enum logic [OpW-1:0] {
    OpSpawn   = 2'd0,
    OpDestroy = 2'd1,
    OpAlive   = 2'd2,
    OpGet     = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StRange = 2'd2,
    StStale = 2'd3
  } status_e;

  // One word of the slot memory.
  typedef struct packed {
    logic             live;
    logic [GenW-1:0]  gen;
    logic [KindW-1:0] kind;
  } entry_t;

  // Update strobes from the decision logic to the state owner.
  typedef struct packed {
    logic    slot_we;
    logic    push;
    logic    pop;
    logic    take_fresh;
    status_e status;
  } ctl_t;

endpackage

`default_nettype wire

// ===== hdl/gha_decide.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gha_decide #(
  parameter int unsigned SLOT_COUNT = gha_pkg::SlotCountDef
) (
  input  gha_pkg::op_e                       op_i,
  input  logic                               range_err_i,
  input  logic [$clog2(SLOT_COUNT)-1:0]      slot_i,
  input  logic [gha_pkg::GenW-1:0]           gen_i,
  input  logic [gha_pkg::KindW-1:0]          kind_i,
  input  gha_pkg::entry_t                    rdata_i,
  input  logic                               slot0_wr_i,
  input  logic [$clog2(SLOT_COUNT):0]        free_cnt_i,
  input  logic [$clog2(SLOT_COUNT):0]        fresh_next_i,
  input  logic [$clog2(SLOT_COUNT)-1:0]      stk_slot_i,
  input  logic [gha_pkg::GenW-1:0]           stk_gen_i,
  output gha_pkg::ctl_t                      ctl_o,
  output logic [$clog2(SLOT_COUNT)-1:0]      wr_addr_o,
  output gha_pkg::entry_t                    wr_entry_o,
  output logic [$clog2(SLOT_COUNT)-1:0]      res_slot_o,
  output logic [gha_pkg::GenW-1:0]           res_gen_o,
  output logic [gha_pkg::KindW-1:0]          res_kind_o
);
  import gha_pkg::*;

  localparam int unsigned SlotW = $clog2(SLOT_COUNT);
  localparam int unsigned CntW  = SlotW + 1;

  entry_t          eff;
  logic [GenW-1:0] gen_nx;
  logic            match;

  // Slots at or above the fresh mark were never written: they read as reset.
  always_comb begin
    if (slot_i == '0 && !slot0_wr_i) begin
      eff = '{live: 1'b1, gen: '0, kind: '0};
    end else if ({1'b0, slot_i} >= fresh_next_i) begin
      eff = '0;
    end else begin
      eff = rdata_i;
    end
  end

  assign gen_nx = (eff.gen == GenMax) ? '0 : eff.gen + GenW'(1);
  assign match  = (eff.gen == gen_i);

  always_comb begin
    ctl_o      = '{slot_we: 1'b0, push: 1'b0, pop: 1'b0, take_fresh: 1'b0, status: StOk};
    wr_addr_o  = slot_i;
    wr_entry_o = eff;
    res_slot_o = '0;
    res_gen_o  = '0;
    res_kind_o = '0;
    case (op_i)
      OpSpawn: begin
        if (free_cnt_i != '0) begin
          ctl_o.pop  = 1'b1;
          wr_addr_o  = stk_slot_i;
          wr_entry_o = '{live: 1'b1, gen: stk_gen_i, kind: kind_i};
        end else if (fresh_next_i < CntW'(SLOT_COUNT)) begin
          ctl_o.take_fresh = 1'b1;
          wr_addr_o  = fresh_next_i[SlotW-1:0];
          wr_entry_o = '{live: 1'b1, gen: '0, kind: kind_i};
        end else begin
          ctl_o.status = StFull;
        end
        if (ctl_o.status == StOk) begin
          ctl_o.slot_we = 1'b1;
          res_slot_o    = wr_addr_o;
          res_gen_o     = wr_entry_o.gen;
          res_kind_o    = kind_i;
        end
      end
      OpGet: begin
        if (range_err_i) begin
          ctl_o.status = StRange;
        end else if (!match) begin
          ctl_o.status = StStale;
        end else begin
          res_slot_o = slot_i;
          res_gen_o  = eff.gen;
          res_kind_o = eff.kind;
        end
      end
      OpAlive, OpDestroy: begin
        if (range_err_i) begin
          ctl_o.status = StRange;
        end else if (!match || !eff.live) begin
          ctl_o.status = StStale;
        end else if (op_i == OpDestroy) begin
          ctl_o.slot_we = 1'b1;
          ctl_o.push    = (free_cnt_i < CntW'(SLOT_COUNT));
          wr_entry_o    = '{live: 1'b0, gen: gen_nx, kind: eff.kind};
          res_slot_o    = slot_i;
          res_gen_o     = gen_nx;
          res_kind_o    = eff.kind;
        end else begin
          res_slot_o = slot_i;
          res_gen_o  = eff.gen;
          res_kind_o = eff.kind;
        end
      end
      default: begin
        ctl_o.status = StStale;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/generational_handle_allocator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake           Payload
// -------   ---------           -------
// command   start / busy        op_i, slot_index_i, generation_tag_i, kind_code_i
// result    done_o (strobe)     status_o, result_slot_o, result_generation_o, result_kind_o
//
// An item is taken at an edge with start high and busy low. The capture step reads the
// slot memory and the free stack; the decide step decides, writes both memories back and
// loads the result register, so done_o is high in the cycle after busy; the split
// follows from the registered reads of the memories before write-back.
// A new item may be taken in the cycle that done_o shows the previous result.
// Reset is ready at once: never-used slots above the fresh mark read as reset value,
// and slot zero reads live until first written. The receiver cannot stall.

module generational_handle_allocator_unit #(
  parameter int unsigned SLOT_COUNT = gha_pkg::SlotCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [gha_pkg::OpW-1:0]       op_i,
  input  logic [gha_pkg::SlotIdxW-1:0]  slot_index_i,
  input  logic [gha_pkg::GenW-1:0]      generation_tag_i,
  input  logic [gha_pkg::KindW-1:0]     kind_code_i,
  output logic                          done_o,
  output logic [gha_pkg::StatusW-1:0]   status_o,
  output logic [gha_pkg::ResSlotW-1:0]  result_slot_o,
  output logic [gha_pkg::GenW-1:0]      result_generation_o,
  output logic [gha_pkg::KindW-1:0]     result_kind_o
);
  import gha_pkg::*;

  localparam int unsigned SlotW = $clog2(SLOT_COUNT);
  localparam int unsigned CntW  = SlotW + 1;
  localparam int unsigned ExtW  = (CntW > SlotIdxW) ? CntW : SlotIdxW;
  localparam int unsigned StkW  = SlotW + GenW;

  // Slot memory {live, gen, kind} and the LIFO of freed {slot, gen}.
  entry_t               slot_mem [SLOT_COUNT];
  logic [StkW-1:0]      stk_mem  [SLOT_COUNT];

  logic                 accept;
  logic [ExtW-1:0]      slot_ext;
  logic [SlotW-1:0]     stk_raddr;

  // Request held through the decide cycle.
  op_e                  op_q;
  logic [SlotW-1:0]     slot_q;
  logic                 range_q;
  logic [GenW-1:0]      gen_q;
  logic [KindW-1:0]     kind_q;

  entry_t               slot_rd_q;
  logic [StkW-1:0]      stk_rd_q;

  logic                 busy_q;
  logic [CntW-1:0]      free_cnt_q, free_cnt_d;
  logic [CntW-1:0]      fresh_next_q, fresh_next_d;
  logic                 slot0_wr_q, slot0_wr_d;

  ctl_t                 ctl;
  logic [SlotW-1:0]     wr_addr;
  entry_t               wr_entry;
  logic [SlotW-1:0]     res_slot;
  logic [GenW-1:0]      res_gen;
  logic [KindW-1:0]     res_kind;
  logic                 slot_we, push, pop, take_fresh;

  logic                 done_q;
  status_e              status_q;
  logic [SlotW-1:0]     res_slot_q;
  logic [GenW-1:0]      res_gen_q;
  logic [KindW-1:0]     res_kind_q;

  assign accept    = start && !busy_q;
  assign slot_ext  = ExtW'(slot_index_i);
  assign stk_raddr = SlotW'(free_cnt_q - CntW'(1));

  // Capture the request and issue both memory reads.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= op_e'(op_i);
      slot_q    <= slot_ext[SlotW-1:0];
      range_q   <= (slot_ext >= ExtW'(SLOT_COUNT));
      gen_q     <= generation_tag_i;
      kind_q    <= kind_code_i;
      slot_rd_q <= slot_mem[slot_ext[SlotW-1:0]];
      stk_rd_q  <= stk_mem[stk_raddr];
    end
  end

  gha_decide #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_decide (
    .op_i         (op_q),
    .range_err_i  (range_q),
    .slot_i       (slot_q),
    .gen_i        (gen_q),
    .kind_i       (kind_q),
    .rdata_i      (slot_rd_q),
    .slot0_wr_i   (slot0_wr_q),
    .free_cnt_i   (free_cnt_q),
    .fresh_next_i (fresh_next_q),
    .stk_slot_i   (stk_rd_q[StkW-1:GenW]),
    .stk_gen_i    (stk_rd_q[GenW-1:0]),
    .ctl_o        (ctl),
    .wr_addr_o    (wr_addr),
    .wr_entry_o   (wr_entry),
    .res_slot_o   (res_slot),
    .res_gen_o    (res_gen),
    .res_kind_o   (res_kind)
  );

  // Decisions only count in the decide cycle.
  assign slot_we    = busy_q && ctl.slot_we;
  assign push       = busy_q && ctl.push;
  assign pop        = busy_q && ctl.pop;
  assign take_fresh = busy_q && ctl.take_fresh;

  // Write back the slot entry and push freed handles.
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[wr_addr] <= wr_entry;
    end
    if (push) begin
      stk_mem[free_cnt_q[SlotW-1:0]] <= {slot_q, wr_entry.gen};
    end
  end

  always_comb begin
    free_cnt_d   = free_cnt_q;
    fresh_next_d = fresh_next_q;
    slot0_wr_d   = slot0_wr_q;
    if (pop) begin
      free_cnt_d = free_cnt_q - CntW'(1);
    end else if (push) begin
      free_cnt_d = free_cnt_q + CntW'(1);
    end
    if (take_fresh) begin
      fresh_next_d = fresh_next_q + CntW'(1);
    end
    if (slot_we && wr_addr == '0) begin
      slot0_wr_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      done_q       <= 1'b0;
      free_cnt_q   <= '0;
      fresh_next_q <= CntW'(1);
      slot0_wr_q   <= 1'b0;
    end else begin
      busy_q       <= accept;
      done_q       <= busy_q;
      free_cnt_q   <= free_cnt_d;
      fresh_next_q <= fresh_next_d;
      slot0_wr_q   <= slot0_wr_d;
    end
  end

  // Hold the result for its single strobe cycle.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      status_q   <= ctl.status;
      res_slot_q <= res_slot;
      res_gen_q  <= res_gen;
      res_kind_q <= res_kind;
    end
  end

  assign busy                = busy_q;
  assign done_o              = done_q;
  assign status_o            = status_q;
  assign result_slot_o       = ResSlotW'(res_slot_q);
  assign result_generation_o = res_gen_q;
  assign result_kind_o       = res_kind_q;

`ifndef SYNTHESIS
  a_busy_then_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> done_q && !busy_q)
    else $error("result strobe did not follow the decide cycle");

  a_free_le_fresh : assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= fresh_next_q)
    else $error("free stack holds more slots than were ever handed out");

  a_fresh_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_next_q <= CntW'(SLOT_COUNT) && fresh_next_q != '0)
    else $error("fresh slot mark out of bounds");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && status_q != StOk |-> res_slot_q == '0 && res_gen_q == '0 && res_kind_q == '0)
    else $error("error result carries nonzero fields");

  a_one_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({push, pop, take_fresh}) <= 1)
    else $error("conflicting free list updates in one item");
`endif

endmodule

`default_nettype wire
